@@ rtl/random_sample_set_table_defines.svh @@
// Assertion helpers shared by the set table RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef RANDOM_SAMPLE_SET_TABLE_DEFINES_SVH
`define RANDOM_SAMPLE_SET_TABLE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define RSST_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rsst: invariant violated");

// Antecedent implies consequent in the same cycle.
`define RSST_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsst: implication violated");

// Antecedent implies consequent in the next cycle.
`define RSST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsst: next-cycle check violated");

`endif

@@ rtl/rsst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rsst_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int RW_W     = 16;
  localparam int STATUS_W = 3;
  localparam int MCOUNT_W = 7;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic                accept;
    logic                scan;
    logic                ins_wr;
    logic                move_rd;
    logic                move_wr;
    logic                samp_mul;
    logic                samp_rd;
    logic                load_out;
    logic                success;
    logic                take_sample;
    logic [STATUS_W-1:0] status;
  } rsst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic full;
    logic empty;
  } rsst_stat_t;

endpackage
`default_nettype wire

@@ rtl/rsst_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rsst_in_if
  import rsst_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic        [KIND_W-1:0]   kind;
  logic signed [VALUE_W-1:0]  value;
  logic        [RW_W-1:0]     random_word;

  modport source (output valid, output kind, output value, output random_word,
                  input ready);
  modport sink   (input valid, input kind, input value, input random_word,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/rsst_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rsst_out_if
  import rsst_pkg::*;
  ;
  logic                       valid;
  logic                       ready;
  logic                       success;
  logic signed [VALUE_W-1:0]  sampled_value;
  logic        [STATUS_W-1:0] status;
  logic        [MCOUNT_W-1:0] member_count;

  modport source (output valid, output success, output sampled_value, output status,
                  output member_count, input ready);
  modport sink   (input valid, input success, input sampled_value, input status,
                  input member_count, output ready);
endinterface
`default_nettype wire

@@ rtl/rsst_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "random_sample_set_table_defines.svh"
module rsst_datapath
  import rsst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rsst_cmd_t                  cmd,
  output      rsst_stat_t                 st,
  input  wire logic        [VALUE_W-1:0]  in_value,
  input  wire logic        [RW_W-1:0]     in_random_word,
  output      logic                       res_success,
  output      logic        [VALUE_W-1:0]  res_sampled,
  output      logic        [STATUS_W-1:0] res_status,
  output      logic        [MCOUNT_W-1:0] res_count
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PROD_W = RW_W + CNT_W;

  logic [VALUE_W-1:0]  mem [CAPACITY];

  logic [VALUE_W-1:0]  value_r;
  logic [RW_W-1:0]     rw_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    rd_idx_r;
  logic                cmp_vld_r;
  logic [ADDR_W-1:0]   cmp_idx_r;
  logic [ADDR_W-1:0]   slot_r;
  logic [ADDR_W-1:0]   samp_idx_r;
  logic [VALUE_W-1:0]  rd_data_r;

  logic                success_r;
  logic [VALUE_W-1:0]  sampled_r;
  logic [STATUS_W-1:0] status_r;
  logic [MCOUNT_W-1:0] mcount_r;

  logic                scan_rd;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VALUE_W-1:0]  wr_data;
  logic [ADDR_W-1:0]   last_idx;
  logic [PROD_W-1:0]   prod;
  logic [CNT_W+MCOUNT_W-1:0] count_ext;

  assign scan_rd  = cmd.scan && (rd_idx_r != count_r);
  assign last_idx = ADDR_W'(count_r - 1'b1);
  assign prod     = PROD_W'(rw_r) * PROD_W'(count_r);
  assign count_ext = {{MCOUNT_W{1'b0}}, count_r};

  // read port: scan, move source, or sample pick
  always_comb begin
    rd_en   = scan_rd || cmd.move_rd || cmd.samp_rd;
    priority if (scan_rd) begin
      rd_addr = ADDR_W'(rd_idx_r);
    end else if (cmd.move_rd) begin
      rd_addr = last_idx;
    end else begin
      rd_addr = samp_idx_r;
    end
  end

  // write port: append on insert, fill the hole on remove
  always_comb begin
    wr_en   = cmd.ins_wr || cmd.move_wr;
    wr_addr = slot_r;
    wr_data = rd_data_r;
    if (cmd.ins_wr) begin
      wr_addr = ADDR_W'(count_r);
      wr_data = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else if (scan_rd) begin
        rd_idx_r  <= rd_idx_r + 1'b1;
        cmp_vld_r <= 1'b1;
      end else begin
        cmp_vld_r <= 1'b0;
      end
      if (cmd.ins_wr) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.move_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r <= in_value;
      rw_r    <= in_random_word;
    end
    if (scan_rd) begin
      cmp_idx_r <= ADDR_W'(rd_idx_r);
    end
    if (st.hit) begin
      slot_r <= cmp_idx_r;
    end
    if (cmd.samp_mul) begin
      samp_idx_r <= prod[RW_W +: ADDR_W];
    end
    if (cmd.load_out) begin
      success_r <= cmd.success;
      sampled_r <= cmd.take_sample ? rd_data_r : '0;
      status_r  <= cmd.status;
      mcount_r  <= count_ext[MCOUNT_W-1:0];
    end
  end

  always_comb begin
    st.hit       = cmd.scan && cmp_vld_r && (rd_data_r == value_r);
    st.scan_done = (rd_idx_r == count_r) && !cmp_vld_r;
    st.full      = (count_r == CNT_W'(CAPACITY));
    st.empty     = (count_r == '0);
  end

  assign res_success = success_r;
  assign res_sampled = sampled_r;
  assign res_status  = status_r;
  assign res_count   = mcount_r;

  `RSST_HOLDS(a_count_cap, count_r <= CNT_W'(CAPACITY))
  `RSST_IMPLIES(a_ins_room, cmd.ins_wr, !st.full)
  `RSST_IMPLIES(a_move_slot, cmd.move_wr, (!st.empty) && (CNT_W'(slot_r) < count_r))
  `RSST_IMPLIES(a_samp_idx, cmd.samp_rd, CNT_W'(samp_idx_r) < count_r)
  `RSST_NEXT(a_ins_grows, cmd.ins_wr, count_r == CNT_W'($past(count_r) + 1'b1))

endmodule
`default_nettype wire

@@ rtl/rsst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rsst_ctrl
  import rsst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      rsst_cmd_t         cmd,
  input  wire rsst_stat_t        st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_INS_WR,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SAMP_MUL,
    S_SAMP_RD,
    S_RESULT
  } state_t;

  state_t              state_r;
  logic [KIND_W-1:0]   kind_r;
  logic                res_ok_r;
  logic                res_take_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                out_valid_r;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd             = '0;
    cmd.accept      = (state_r == S_IDLE) && in_valid;
    cmd.scan        = (state_r == S_SEARCH);
    cmd.ins_wr      = (state_r == S_INS_WR);
    cmd.move_rd     = (state_r == S_MOVE_RD);
    cmd.move_wr     = (state_r == S_MOVE_WR);
    cmd.samp_mul    = (state_r == S_SAMP_MUL);
    cmd.samp_rd     = (state_r == S_SAMP_RD);
    cmd.load_out    = (state_r == S_RESULT) && out_free;
    cmd.success     = res_ok_r;
    cmd.take_sample = res_take_r;
    cmd.status      = res_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kind_r       <= KIND_INSERT;
      res_ok_r     <= 1'b0;
      res_take_r   <= 1'b0;
      res_status_r <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      // drop valid after its transfer unless a new result is posted now
      if (out_valid_r && out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= in_kind;
            res_ok_r   <= 1'b0;
            res_take_r <= 1'b0;
            unique case (in_kind)
              KIND_INSERT, KIND_REMOVE: begin
                res_status_r <= ST_OK;
                state_r      <= S_SEARCH;
              end
              KIND_SAMPLE: begin
                if (st.empty) begin
                  res_status_r <= ST_EMPTY;
                  state_r      <= S_RESULT;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_SAMP_MUL;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                state_r      <= S_RESULT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          priority if (st.hit) begin
            if (kind_r == KIND_REMOVE) begin
              state_r <= S_MOVE_RD;
            end else begin
              res_status_r <= ST_PRESENT;
              state_r      <= S_RESULT;
            end
          end else if (st.scan_done) begin
            if (kind_r == KIND_REMOVE) begin
              res_status_r <= ST_ABSENT;
              state_r      <= S_RESULT;
            end else if (st.full) begin
              res_status_r <= ST_FULL;
              state_r      <= S_RESULT;
            end else begin
              state_r <= S_INS_WR;
            end
          end else begin
            // hold: scan still running
            state_r <= S_SEARCH;
          end
        end
        S_INS_WR: begin
          res_ok_r <= 1'b1;
          state_r  <= S_RESULT;
        end
        S_MOVE_RD: begin
          state_r <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          res_ok_r <= 1'b1;
          state_r  <= S_RESULT;
        end
        S_SAMP_MUL: begin
          state_r <= S_SAMP_RD;
        end
        S_SAMP_RD: begin
          res_ok_r   <= 1'b1;
          res_take_r <= 1'b1;
          state_r    <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/random_sample_set_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Handshake        Payload
// in_chan    in   valid / ready    kind, value, random_word
// out_chan   out  valid / ready    success, sampled_value, status, member_count
//
// Steps from an input transfer to out_valid: insert scans the live entries, writes,
// posts; remove hit scans to the slot, moves the last entry into the hole, posts;
// remove miss, duplicate or full insert scan and post; sample multiplies, reads, posts;
// empty sample or unused code posts at once. in_ready rises together with out_valid.
// Reset (rst_n low, synchronous) empties the set; the store itself is not cleared.
// A new item is taken while the previous result waits; a stalled output holds
// the finished result in its state until the output register frees up.
module random_sample_set_table
  import rsst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rsst_in_if.sink    in_chan,
  rsst_out_if.source out_chan
);

  rsst_cmd_t           cmd;
  rsst_stat_t          st;
  logic                res_success;
  logic [VALUE_W-1:0]  res_sampled;
  logic [STATUS_W-1:0] res_status;
  logic [MCOUNT_W-1:0] res_count;

  // sequencer: accepts a transfer, steps the scan / move / sample, posts result
  rsst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .st        (st)
  );

  // value store, live count, compare and sample index, output register
  rsst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_value       (in_chan.value),
    .in_random_word (in_chan.random_word),
    .res_success    (res_success),
    .res_sampled    (res_sampled),
    .res_status     (res_status),
    .res_count      (res_count)
  );

  assign out_chan.success       = res_success;
  assign out_chan.sampled_value = res_sampled;
  assign out_chan.status        = res_status;
  assign out_chan.member_count  = res_count;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import rsst_pkg::*;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int POOL_SIZE       = 80;   // a bit larger than CAPACITY, so full inserts occur
  localparam int PHASE_ITEMS     = 150;
  localparam int HOLD_OFF_CYCLES = 300;  // receiver hold-off, long enough to back up the input
  localparam int TAIL_CYCLES     = 2 * CAPACITY + 16;  // worst scan plus remove move, doubled
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int REPORT_LIMIT    = 20;

  // One reply of the block, field by field.
  typedef struct {
    logic                       success;
    logic signed [VALUE_W-1:0]  sampled_value;
    logic        [STATUS_W-1:0] status;
    logic        [MCOUNT_W-1:0] member_count;
  } set_reply_t;

  // Mirror of the set: computes the reply of each accepted request and
  // holds the replies still owed by the block, oldest first.
  class set_tracker;
    logic signed [VALUE_W-1:0] members [CAPACITY];
    int unsigned live;
    set_reply_t  expected_replies [$];
    int unsigned errors;
    int unsigned peak;
    int unsigned kind_seen [4];
    int unsigned status_seen [8];

    function void note_request(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value,
                               logic [RW_W-1:0] rw);
      set_reply_t r;
      int         slot;
      int unsigned pick;
      r.success       = 1'b0;
      r.sampled_value = '0;
      r.status        = ST_OK;
      // Associative search over the live entries only.
      slot = -1;
      for (int i = 0; i < live; i++)
        if (slot < 0 && members[i] == value) slot = i;
      case (kind)
        KIND_INSERT: begin
          // Duplicate check wins over the full check.
          if (slot >= 0) r.status = ST_PRESENT;
          else if (live >= CAPACITY) r.status = ST_FULL;
          else begin
            members[live] = value;
            live++;
            r.success = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (slot < 0) r.status = ST_ABSENT;
          else begin
            // Fill the hole with the last live entry.
            members[slot] = members[live-1];
            live--;
            r.success = 1'b1;
          end
        end
        KIND_SAMPLE: begin
          if (live == 0) r.status = ST_EMPTY;
          else begin
            pick            = (32'(rw) * live) >> 16;
            r.sampled_value = members[pick];
            r.success       = 1'b1;
          end
        end
        default: ;
      endcase
      r.member_count = MCOUNT_W'(live);
      if (live > peak) peak = live;
      kind_seen[kind]++;
      status_seen[r.status]++;
      expected_replies = {expected_replies, r};
    endfunction

    function void flag(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_reply(set_reply_t got);
      set_reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: reply with none outstanding, got success %0b value %0h status %0d count %0d",
                   $time, got.success, got.sampled_value, got.status, got.member_count);
        return;
      end
      want = expected_replies.pop_front();
      if (got.success !== want.success)
        flag("success", VALUE_W'(want.success), VALUE_W'(got.success));
      if (got.sampled_value !== want.sampled_value)
        flag("sampled_value", want.sampled_value, got.sampled_value);
      if (got.status !== want.status)
        flag("status", VALUE_W'(want.status), VALUE_W'(got.status));
      if (got.member_count !== want.member_count)
        flag("member_count", VALUE_W'(want.member_count), VALUE_W'(got.member_count));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rsst_in_if  in_chan ();
  rsst_out_if out_chan ();

  random_sample_set_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  set_tracker tracker = new();

  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
  bit          steady;         // both sides stop idling while set
  bit          hold_off_req;   // sender asks the receiver for one long hold-off
  int unsigned stalled_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both channels at each rising edge: note every request transfer,
  // check every reply transfer, and count cycles with no transfer at all.
  always @(posedge clk) begin : monitor
    set_reply_t observed;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        tracker.note_request(in_chan.kind, in_chan.value, in_chan.random_word);
      if (out_chan.valid && out_chan.ready) begin
        observed.success       = out_chan.success;
        observed.sampled_value = out_chan.sampled_value;
        observed.status        = out_chan.status;
        observed.member_count  = out_chan.member_count;
        tracker.check_reply(observed);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stalled_cycles <= 0;
      else
        stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d replies outstanding", $time,
                 WATCHDOG_LIMIT, tracker.expected_replies.size());
        $display("random_sample_set_table: mismatch");
        $finish;
      end
    end
  end

  // Reply side: accept at random about 70 percent of the time, always while steady,
  // and drop ready for a long counted stretch when the sender asks for it.
  initial begin : reply_sink
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_chan.ready <= steady || ($urandom_range(99) >= 30);
        @(posedge clk);
      end
    end
  end

  // Offer one request, idling first at random, and return at the edge of its
  // transfer. Valid is left high so the next request can follow back to back.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] value,
                           input logic [RW_W-1:0] rw);
    while (!steady && $urandom_range(99) < 30) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.kind        <= kind;
    in_chan.value       <= value;
    in_chan.random_word <= rw;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Hold the input quiet until the block has answered everything.
  task automatic await_all_replies();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_replies.size() != 0) @(posedge clk);
  endtask

  // Growing phases favor inserts, shrinking phases favor removes.
  function automatic logic [KIND_W-1:0] choose_kind(bit grow);
    int unsigned roll;
    roll = $urandom_range(99);
    if (grow) begin
      if (roll < 80) return KIND_INSERT;
      if (roll < 85) return KIND_REMOVE;
      if (roll < 98) return KIND_SAMPLE;
    end else begin
      if (roll < 12) return KIND_INSERT;
      if (roll < 82) return KIND_REMOVE;
      if (roll < 97) return KIND_SAMPLE;
    end
    return KIND_UNUSED;
  endfunction

  // Removes mostly aim at current members so the set drains; inserts mostly
  // draw from the pool so duplicates and a full store both come up. The
  // member list may lag one transfer behind, which only shifts the mix.
  function automatic logic signed [VALUE_W-1:0] choose_value(logic [KIND_W-1:0] kind);
    int unsigned roll;
    int unsigned member_pct;
    int unsigned pool_pct;
    member_pct = (kind == KIND_REMOVE) ? 60 : 10;
    pool_pct   = (kind == KIND_REMOVE) ? 25 : 60;
    roll       = $urandom_range(99);
    if (roll < member_pct && tracker.live != 0)
      return tracker.members[$urandom_range(tracker.live - 1)];
    if (roll < member_pct + pool_pct)
      return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [RW_W-1:0] choose_fraction();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return RW_W'($urandom);
  endfunction

  initial begin : stimulus
    logic [KIND_W-1:0] kind;
    int unsigned       sent;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.kind        <= KIND_INSERT;
    in_chan.value       <= '0;
    in_chan.random_word <= '0;
    steady              = 1'b0;
    hold_off_req        = 1'b0;
    stalled_cycles      = 0;
    // Seed the pool with the value extremes, then random words.
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty set, unused code, value extremes, duplicates, sample
    // index bounds, remove with a move and remove of the last entry.
    send_item(KIND_SAMPLE, 0, 16'h0000);
    send_item(KIND_SAMPLE, 0, 16'hffff);
    send_item(KIND_REMOVE, 5, 16'h0000);
    send_item(KIND_UNUSED, 32'shdead_beef, 16'hffff);
    send_item(KIND_INSERT, 32'sh8000_0000, 16'h0000);
    send_item(KIND_INSERT, 32'sh7fff_ffff, 16'h0000);
    send_item(KIND_INSERT, 0, 16'h0000);
    send_item(KIND_INSERT, -1, 16'h0000);
    send_item(KIND_INSERT, 32'sh8000_0000, 16'hffff);
    send_item(KIND_SAMPLE, 32'sh7fff_ffff, 16'h0000);
    send_item(KIND_SAMPLE, 0, 16'hffff);
    send_item(KIND_SAMPLE, 0, 16'h8000);
    send_item(KIND_REMOVE, 32'sh8000_0000, 16'h0000);
    send_item(KIND_SAMPLE, 0, 16'h0000);
    send_item(KIND_REMOVE, -1, 16'h0000);
    send_item(KIND_REMOVE, 32'sh1234_5678, 16'h0000);
    send_item(KIND_REMOVE, 32'sh7fff_ffff, 16'h0000);
    send_item(KIND_REMOVE, 0, 16'h0000);
    send_item(KIND_REMOVE, 0, 16'h0000);
    send_item(KIND_UNUSED, 0, 16'h0000);
    send_item(KIND_INSERT, 32'sh5555_5555, 16'h0000);
    send_item(KIND_INSERT, 32'shaaaa_aaaa, 16'h0000);
    send_item(KIND_SAMPLE, 0, 16'h5555);
    send_item(KIND_SAMPLE, -1, 16'haaaa);
    await_all_replies();

    // Random: alternate growing and shrinking phases so the set reaches
    // full and empty repeatedly. Unused codes ride along but are not counted.
    for (int phase = 0; phase < 6; phase++) begin
      steady = (phase == 2);
      sent   = 0;
      while (sent < PHASE_ITEMS) begin
        // Back up the block once: the receiver holds off while we keep offering.
        if (phase == 0 && sent == 60) hold_off_req = 1'b1;
        kind = choose_kind(phase % 2 == 0);
        send_item(kind, choose_value(kind), choose_fraction());
        if (kind != KIND_UNUSED) sent++;
      end
      steady = 1'b0;
      if (phase == 3) await_all_replies();
    end

    await_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d samples, %0d unused codes; peak %0d of %0d",
             tracker.kind_seen[KIND_INSERT], tracker.kind_seen[KIND_REMOVE],
             tracker.kind_seen[KIND_SAMPLE], tracker.kind_seen[KIND_UNUSED],
             tracker.peak, CAPACITY);
    $display("replies: ok %0d, duplicate %0d, not found %0d, full %0d, empty %0d",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_PRESENT],
             tracker.status_seen[ST_ABSENT], tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_EMPTY]);
    if (tracker.errors == 0 && tracker.expected_replies.size() == 0)
      $display("random_sample_set_table: match");
    else
      $display("random_sample_set_table: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rsst_pkg.sv
rtl/rsst_in_if.sv
rtl/rsst_out_if.sv
rtl/rsst_datapath.sv
rtl/rsst_ctrl.sv
rtl/random_sample_set_table.sv
tb/tb_top.sv
